FILE: design/mpq_pkg.sv
// shared types and constants for the min priority queue
package mpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int PRI_W    = 16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

FILE: design/mpq_if.sv
// valid/ready channel interfaces for the min priority queue
interface mpq_in_if;
  import mpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [VAL_W-1:0] item_value;
  logic        [PRI_W-1:0] item_priority;

  modport source (output valid, operation, item_value, item_priority, input ready);
  modport sink (input valid, operation, item_value, item_priority, output ready);
endinterface

interface mpq_out_if;
  import mpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] out_value;
  logic        [PRI_W-1:0] out_priority;
  logic                    now_empty;

  modport source (output valid, status, out_value, out_priority, now_empty, input ready);
  modport sink (input valid, status, out_value, out_priority, now_empty, output ready);
endinterface

FILE: design/mpq_cell.sv
// one slot of the sorted chain: holds an entry, shifts left or right with its neighbors
module mpq_cell (
  input  logic                clk,
  input  mpq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  logic                left_stay,
  input  mpq_pkg::entry_t     left_entry,
  input  mpq_pkg::entry_t     right_entry,
  output logic                stay,
  output mpq_pkg::entry_t     entry
);
  import mpq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // entry stays in place when it sorts at or ahead of the new one
  assign stay  = occ && (entry_r.prio <= ctrl.new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq && !stay) begin
      entry_nxt = left_stay ? ctrl.new_entry : left_entry;
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: design/min_priority_queue.sv
// top level of the min priority queue: chain of sorted cells and output register
//
//   channel | dir | handshake   | payload
//   in_ch   | in  | valid/ready | operation, item_value, item_priority
//   out_ch  | out | valid/ready | status, out_value, out_priority, now_empty
//
// one item per cycle unless out_ch stalls; cells compare and shift on transfer
// result is registered on the input transfer and held in an output register
// input is taken while the output register is empty or being drained
// rst_n clears the entry count and output valid; cell contents need no reset
module min_priority_queue (
  input logic clk,
  input logic rst_n,
  mpq_in_if.sink    in_ch,
  mpq_out_if.source out_ch
);
  import mpq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  status_t          status_r;
  status_t          status_nxt;
  entry_t           res_r;
  entry_t           res_nxt;
  logic             now_empty_r;
  logic             now_empty_nxt;

  logic       accept;
  logic       is_full;
  logic       is_empty;
  cell_ctrl_t ctrl;

  logic   [CAPACITY-1:0] occ;
  logic   [CAPACITY-1:0] stay;
  entry_t                cell_entry [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == CNT_W'(CAPACITY));
  assign is_empty    = (count_r == '0);

  assign ctrl.enq             = accept && (op_t'(in_ch.operation) == OP_ENQ) && !is_full;
  assign ctrl.deq             = accept && (op_t'(in_ch.operation) == OP_DEQ) && !is_empty;
  assign ctrl.new_entry.value = in_ch.item_value;
  assign ctrl.new_entry.prio  = in_ch.item_priority;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_s;

    assign occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_s = 1'b1;
      assign left_e = ctrl.new_entry;
    end else begin : g_mid
      assign left_s = stay[i-1];
      assign left_e = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[i]),
      .left_stay   (left_s),
      .left_entry  (left_e),
      .right_entry (right_e),
      .stay        (stay[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    res_nxt       = res_r;
    now_empty_nxt = now_empty_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (op_t'(in_ch.operation) == OP_ENQ) begin
        now_empty_nxt = 1'b0;
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_ENQUEUED;
          count_nxt  = count_r + 1'b1;
        end
      end else begin
        if (is_empty) begin
          status_nxt    = ST_EMPTY;
          now_empty_nxt = 1'b1;
        end else begin
          status_nxt    = ST_DEQUEUED;
          res_nxt       = cell_entry[0];
          count_nxt     = count_r - 1'b1;
          now_empty_nxt = (count_r == CNT_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r    <= status_nxt;
    res_r       <= res_nxt;
    now_empty_r <= now_empty_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_value    = res_r.value;
  assign out_ch.out_priority = res_r.prio;
  assign out_ch.now_empty    = now_empty_r;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_deq_count : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.deq |=> count_r == $past(count_r) - 1'b1)
    else $error("dequeue did not lower entry count");

  a_head_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    occ[1] |-> cell_entry[0].prio <= cell_entry[1].prio)
    else $error("head entry out of order");

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> now_empty_r)
    else $error("empty status without empty flag");
`endif

endmodule

FILE: bench/min_priority_queue_tb.sv
// self-checking testbench for the min priority queue: directed and random enqueue/dequeue traffic
module min_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  typedef struct {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
    int unsigned             gap;
    int unsigned             stall_pct;
    bit                      drain_first;
  } queue_op_t;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
    logic                    empty;
  } queue_result_t;

  logic clk;
  logic rst_n;

  mpq_in_if  in_bus ();
  mpq_out_if out_bus ();

  min_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  queue_op_t     pending[$];
  queue_result_t expected_results[$];

  logic signed [VAL_W-1:0] held_values[CAPACITY];
  logic        [PRI_W-1:0] held_prios[CAPACITY];
  int                      held_count = 0;

  bit          in_took = 1'b0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_stall_left = 0;
  int          errors = 0;
  int          n_enq = 0, n_deq = 0, n_full = 0, n_empty = 0, peak_depth = 0;

  function automatic queue_result_t apply_to_queue(op_t op, logic signed [VAL_W-1:0] value,
                                                   logic [PRI_W-1:0] prio);
    queue_result_t r;
    int pos;
    r.status = ST_ENQUEUED;
    r.value  = '0;
    r.prio   = '0;
    r.empty  = 1'b0;
    if (op == OP_ENQ) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
        r.empty  = (held_count == 0);
        n_full++;
      end else begin
        pos = 0;
        while (pos < held_count && held_prios[pos] <= prio) pos++;
        for (int k = held_count; k > pos; k--) begin
          held_values[k] = held_values[k-1];
          held_prios[k]  = held_prios[k-1];
        end
        held_values[pos] = value;
        held_prios[pos]  = prio;
        held_count++;
        if (held_count > peak_depth) peak_depth = held_count;
        n_enq++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
        r.empty  = 1'b1;
        n_empty++;
      end else begin
        r.status = ST_DEQUEUED;
        r.value  = held_values[0];
        r.prio   = held_prios[0];
        for (int k = 1; k < held_count; k++) begin
          held_values[k-1] = held_values[k];
          held_prios[k-1]  = held_prios[k];
        end
        held_count--;
        r.empty = (held_count == 0);
        n_deq++;
      end
    end
    return r;
  endfunction

  function automatic logic [PRI_W-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return PRI_W'($urandom_range(7));
    if (sel == 4) return $urandom_range(1) ? '1 : '0;
    if (sel == 5) return PRI_W'($urandom_range(16'hFFFF, 16'hFFF0));
    if (sel == 6) return PRI_W'($urandom_range(15));
    return PRI_W'($urandom);
  endfunction

  task automatic add_op(input op_t op, input logic signed [VAL_W-1:0] value,
                        input logic [PRI_W-1:0] prio, input int unsigned tx_pct,
                        input int unsigned rx_pct, input bit drain_first);
    queue_op_t q;
    q.op          = op;
    q.value       = value;
    q.prio        = prio;
    q.gap         = ($urandom_range(99) < tx_pct) ? $urandom_range(13, 1) : 0;
    q.stall_pct   = rx_pct;
    q.drain_first = drain_first;
    pending.push_back(q);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin : drive_in
    queue_op_t q;
    if (rst_n) begin
      if (!in_bus.valid || in_took) begin
        if (pending.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (pending[0].drain_first && expected_results.size() != 0) begin
          in_bus.valid <= 1'b0;
        end else if (pending[0].gap != 0) begin
          pending[0].gap = pending[0].gap - 1;
          in_bus.valid <= 1'b0;
        end else begin
          q = pending.pop_front();
          rx_stall_pct = q.stall_pct;
          in_bus.operation     <= q.op;
          in_bus.item_value    <= q.value;
          in_bus.item_priority <= q.prio;
          in_bus.valid         <= 1'b1;
        end
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_stall_left != 0) begin
        rx_stall_left--;
        out_bus.ready <= 1'b0;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        rx_stall_left = $urandom_range(13, 1) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : watch
    queue_result_t want;
    if (rst_n) begin
      in_took = in_bus.valid && in_bus.ready;
      if (in_took)
        expected_results.push_back(apply_to_queue(op_t'(in_bus.operation), in_bus.item_value,
                                                  in_bus.item_priority));
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_bus.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_bus.status);
            errors++;
          end
          if (out_bus.out_value !== want.value) begin
            $error("out_value expected %0d got %0d", want.value, out_bus.out_value);
            errors++;
          end
          if (out_bus.out_priority !== want.prio) begin
            $error("out_priority expected %0d got %0d", want.prio, out_bus.out_priority);
            errors++;
          end
          if (out_bus.now_empty !== want.empty) begin
            $error("now_empty expected %0d got %0d", want.empty, out_bus.now_empty);
            errors++;
          end
        end
      end
    end else begin
      in_took = 1'b0;
    end
  end

  initial begin : stimulus
    logic [PRI_W-1:0] dir_prios[17];
    logic signed [VAL_W-1:0] dir_values[17];
    int unsigned enq_mix[7];
    int unsigned idle_mix[4];
    int unsigned enq_pct, tx_pct, rx_pct;
    bit in_tail;

    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.operation     = OP_ENQ;
    in_bus.item_value    = '0;
    in_bus.item_priority = '0;
    out_bus.ready        = 1'b0;

    dir_prios  = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'd5, 16'd5, 16'd5, 16'h0001,
                   16'hFFFE, 16'h0000, 16'hFFFF, 16'd3, 16'h5555, 16'hAAAA, 16'd5, 16'h1234,
                   16'h0000};
    dir_values = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh0, -32'sd1, 32'sd1, 32'sd2, 32'sd3,
                   32'sh55555555, 32'shAAAAAAAA, 32'sd10, 32'sd11, 32'sd12, 32'sd13,
                   32'sd14, 32'sd4, 32'sd15, 32'sd99};
    enq_mix  = '{75, 25, 50, 90, 10, 60, 40};
    idle_mix = '{0, 10, 40, 25};

    // empty dequeue, fill past capacity, then drain a few to see tie order
    add_op(OP_DEQ, $urandom, PRI_W'($urandom), 0, 0, 1'b0);
    for (int i = 0; i < 17; i++) add_op(OP_ENQ, dir_values[i], dir_prios[i], 0, 0, 1'b0);
    for (int i = 0; i < 6; i++) add_op(OP_DEQ, $urandom, PRI_W'($urandom), 0, 0, 1'b0);

    for (int seg = 0; seg < 13; seg++) begin
      in_tail = (seg >= 11);
      enq_pct = enq_mix[seg % 7];
      tx_pct  = in_tail ? 0 : idle_mix[seg % 4];
      rx_pct  = in_tail ? 0 : idle_mix[(seg + 1) % 4];
      for (int i = 0; i < 148; i++) begin
        add_op(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ, $urandom, pick_priority(),
               tx_pct, rx_pct, (i == 0) && (seg % 3 == 0) && !in_tail);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (pending.size() != 0 || in_bus.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d enqueues, %0d refused as full, %0d dequeues, %0d on empty",
             n_enq, n_full, n_deq, n_empty);
    $display("peak queue depth %0d of %0d", peak_depth, CAPACITY);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
